/* hw/rtl/pip_pkg.sv */
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int NUM_W   = $clog2(MAX_VERTICES + 1);
  localparam int VIDX_W  = 6;
  localparam int CNT_W   = 7;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic             load_point;
    logic             clr_count;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } stat_t;

endpackage

/* hw/rtl/point_in_polygon_test.sv */
// Vertex write: busy stays low, so writes may come on every cycle.
// Query over n vertices, one edge per cycle from the single vertex store read port;
// done is raised once the edge pipeline has drained. Reset (rst, synchronous) returns
// to idle, sets vertex_count to 3 and keeps the store; the receiver cannot stall done.
module point_in_polygon_test (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   opcode,
  input  logic [pip_pkg::VIDX_W-1:0]             vertex_index,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_y,
  output logic                                   done,
  output logic                                   inside_res,
  output logic [pip_pkg::CNT_W-1:0]              crossings,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pip_pkg::CNT_W-1:0]              cfg_data
);
  import pip_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t             cmd;
  stat_t            stat;
  logic [NUM_W-1:0] count;

  // The configuration register can take a transaction on any cycle; the host is to
  // write it only while the block is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // The controller owns the vertex_count register and walks the read
  // addresses: vertex zero first, then each following vertex, then vertex
  // zero again, so that every read after the first closes one edge.
  pip_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .vertex_index (vertex_index),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done)
  );

  // The datapath holds the vertex store and a three-stage edge pipeline:
  // edge ordering and differences, the two cross products, and the compare
  // that bumps the crossing counter.
  pip_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .point_x      (point_x),
    .point_y      (point_y),
    .stat         (stat),
    .count        (count)
  );

  // The counter is stable once the pipeline has drained, which is when the
  // controller raises done.
  assign crossings  = CNT_W'(count);
  assign inside_res = count[0];

  // A query transaction keeps the block busy until its result is delivered.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  // A vertex write completes in its accept cycle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_WRITE) |=> !busy)
    else $error("vertex write left the block busy");

  // A result only appears while a query is in flight, and it ends the query.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a query");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block still busy after result");

  // The count never exceeds the number of edges in the store.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(count) <= MAX_VERTICES))
    else $error("crossing count out of range");

endmodule

/* hw/rtl/pip_ctrl.sv */
module pip_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       opcode,
  input  logic [pip_pkg::VIDX_W-1:0] vertex_index,
  input  logic                       cfg_valid,
  input  logic [pip_pkg::CNT_W-1:0]  cfg_data,
  input  pip_pkg::stat_t             stat,
  output pip_pkg::cmd_t              cmd,
  output logic                       busy,
  output logic                       done
);
  import pip_pkg::*;

  state_t             state, state_next;
  logic [NUM_W-1:0]   k, k_next;
  logic [NUM_W-1:0]   n, n_next;
  logic [CNT_W-1:0]   vertex_count;
  logic [NUM_W-1:0]   n_sat;
  logic               accept;

  // Counts above the store depth saturate to the depth.
  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) begin
      n_sat = NUM_W'(MAX_VERTICES);
    end else begin
      n_sat = NUM_W'(vertex_count);
    end
  end

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      k            <= '0;
      n            <= '0;
      vertex_count <= CNT_W'(3);
    end else begin
      state <= state_next;
      k     <= k_next;
      n     <= n_next;
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next     = state;
    k_next         = k;
    n_next         = n;
    cmd            = '0;
    busy           = 1'b1;
    done           = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept && opcode == OP_WRITE) begin
          cmd.wr_en = (32'(vertex_index) < MAX_VERTICES);
        end
        if (accept && opcode == OP_QUERY) begin
          cmd.load_point = 1'b1;
          cmd.clr_count  = 1'b1;
          n_next         = n_sat;
          k_next         = '0;
          state_next     = (n_sat == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        // Addresses 0..n-1 and then vertex zero again to close the polygon.
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k == '0);
        cmd.rd_addr  = (k == n) ? '0 : k[IDX_W-1:0];
        k_next       = k + 1'b1;
        if (k == n) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/pip_datapath.sv */
module pip_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pip_pkg::cmd_t                          cmd,
  input  logic [pip_pkg::VIDX_W-1:0]             vertex_index,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] point_y,
  output pip_pkg::stat_t                         stat,
  output logic [pip_pkg::NUM_W-1:0]              count
);
  import pip_pkg::*;

  logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_data;
  logic                     rd_vld, rd_first;

  logic signed [COORD_WIDTH-1:0] px, py;
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;
  logic signed [COORD_WIDTH-1:0] cur_x, cur_y;
  logic signed [COORD_WIDTH-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                          between;

  logic signed [DIFF_W-1:0] ea, eb, ec, ed;
  logic                     e_vld;
  logic signed [PROD_W-1:0] p1, p2;
  logic                     p_vld;

  // Vertex store: x in the upper half, y in the lower half.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[IDX_W'(vertex_index)] <= {point_x, point_y};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  assign cur_x = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign cur_y = rd_data[COORD_WIDTH-1:0];

  // Order the edge ends by x; a vertical edge fails the strict between test.
  always_comb begin
    if (cur_x < prev_x) begin
      lo_x = cur_x;  lo_y = cur_y;  hi_x = prev_x; hi_y = prev_y;
    end else begin
      lo_x = prev_x; lo_y = prev_y; hi_x = cur_x;  hi_y = cur_y;
    end
    between = (lo_x < px) && (px < hi_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      e_vld    <= 1'b0;
      p_vld    <= 1'b0;
      count    <= '0;
    end else begin
      rd_vld   <= cmd.rd_en;
      rd_first <= cmd.rd_first;
      e_vld    <= rd_vld && !rd_first && between;
      p_vld    <= e_vld;
      if (cmd.clr_count) begin
        count <= '0;
      end else if (p_vld && (p1 < p2)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      px <= point_x;
      py <= point_y;
    end
    if (rd_vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    // Line above the point: (py - y1) * dx < dy * (px - x1), with dx > 0.
    ea <= DIFF_W'(py) - DIFF_W'(lo_y);
    eb <= DIFF_W'(hi_x) - DIFF_W'(lo_x);
    ec <= DIFF_W'(hi_y) - DIFF_W'(lo_y);
    ed <= DIFF_W'(px) - DIFF_W'(lo_x);
    p1 <= ea * eb;
    p2 <= ec * ed;
  end

  assign stat.pipe_busy = rd_vld || e_vld || p_vld;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import pip_pkg::*;

  // A query walks the edges in the store and then drains the edge pipeline,
  // so a quiet wait of this length after the last result covers any late strobe.
  localparam int LATENCY_CYCLES = MAX_VERTICES + 8;
  // Longest correct quiet stretch is one full query or one settle period.
  // The limit is many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_OPS     = 1200;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One vertex write or point query waiting to be driven.
  typedef struct {
    logic              opcode;
    logic [VIDX_W-1:0] slot;
    coord_t            x;
    coord_t            y;
  } polygon_op_t;

  // The result that a query should produce, with its point kept for messages.
  typedef struct {
    logic             odd;
    logic [CNT_W-1:0] count;
    coord_t           x;
    coord_t           y;
  } crossing_result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic              opcode       = OP_WRITE;
  logic [VIDX_W-1:0] vertex_index = '0;
  coord_t            point_x      = '0;
  coord_t            point_y      = '0;
  logic              cfg_valid    = 1'b0;
  logic [CNT_W-1:0]  cfg_data     = '0;
  logic              busy;
  logic              done;
  logic              inside_res;
  logic [CNT_W-1:0]  crossings;
  logic              cfg_ready;

  // Operations waiting for the driver, and query results still owed by the block.
  polygon_op_t      polygon_ops[$];
  crossing_result_t predicted_crossings[$];

  // Shadow of the block state, updated as each transaction is accepted.
  coord_t           shadow_x[MAX_VERTICES];
  coord_t           shadow_y[MAX_VERTICES];
  logic [CNT_W-1:0] shadow_count = CNT_W'(3);

  // Polygon as the stimulus planned it. Operations are accepted in queue order,
  // so this tells which slots will be written before a planned query runs.
  coord_t                  plan_x[MAX_VERTICES];
  coord_t                  plan_y[MAX_VERTICES];
  logic [MAX_VERTICES-1:0] plan_written = '0;

  int queued_ops     = 0;
  int accepted_ops   = 0;
  int mismatch_count = 0;
  int gap_pct        = 33;
  int quiet_cycles   = 0;

  int unsigned corner_counts[9] = '{64, 0, 1, 2, 127, 65, 3, 100, 63};

  point_in_polygon_test i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .vertex_index (vertex_index),
    .point_x      (point_x),
    .point_y      (point_y),
    .done         (done),
    .inside_res   (inside_res),
    .crossings    (crossings),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Crossing count for an upward ray from (px, py) over the closed polygon
  // held in the shadow store. The comparison is the exact cross-multiplied
  // form: the edge line at px lies strictly above py. Products need about
  // 34 bits, so 64-bit arithmetic holds them without loss.
  function automatic logic [CNT_W-1:0] count_crossings(input coord_t px, input coord_t py);
    int               n;
    int               i;
    int               j;
    longint           x1;
    longint           y1;
    longint           x2;
    longint           y2;
    longint           qx;
    longint           qy;
    longint           t;
    logic [CNT_W-1:0] total;
    // A register value beyond the store size is clamped to the store size.
    n     = (shadow_count > MAX_VERTICES) ? MAX_VERTICES : int'(shadow_count);
    total = '0;
    qx    = longint'(px);
    qy    = longint'(py);
    for (i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      x1 = longint'(shadow_x[i]);
      y1 = longint'(shadow_y[i]);
      x2 = longint'(shadow_x[j]);
      y2 = longint'(shadow_y[j]);
      // Vertical edges never count.
      if (x1 != x2) begin
        if (x2 < x1) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        // Strict bounds on x drop points at either end x, and the strict
        // comparison drops points that lie on the line itself.
        if (x1 < qx && qx < x2 && (qy - y1) * (x2 - x1) < (y2 - y1) * (qx - x1))
          total = total + 1'b1;
      end
    end
    return total;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endtask

  // Driver. The transaction on the ports is accepted at an edge where start
  // is high and busy is low; its effect is folded into the shadow state right
  // there, in acceptance order. A new operation is offered whenever the port
  // is free, with random gaps at the rate that gap_pct sets.
  always @(posedge clk) begin
    polygon_op_t      op;
    crossing_result_t res;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (opcode == OP_WRITE) begin
          shadow_x[vertex_index] = point_x;
          shadow_y[vertex_index] = point_y;
        end else begin
          res.count = count_crossings(point_x, point_y);
          res.odd   = res.count[0];
          res.x     = point_x;
          res.y     = point_y;
          predicted_crossings.insert(predicted_crossings.size(), res);
        end
        accepted_ops++;
      end
      if (!start || !busy) begin
        if (polygon_ops.size() != 0 && $urandom_range(99) >= gap_pct) begin
          op = polygon_ops.pop_front();
          opcode       <= op.opcode;
          vertex_index <= op.slot;
          point_x      <= op.x;
          point_y      <= op.y;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. The done strobe lasts one cycle and cannot be held off, so every
  // edge with done high carries one result, matched against the oldest query.
  always @(posedge clk) begin
    crossing_result_t want;
    if (!rst && done) begin
      if (predicted_crossings.size() == 0) begin
        note_mismatch($sformatf("result with no query outstanding: inside %0b crossings %0d",
                                inside_res, crossings));
      end else begin
        want = predicted_crossings.pop_front();
        if (inside_res !== want.odd || crossings !== want.count)
          note_mismatch($sformatf("point (%0d,%0d): expected inside %0b crossings %0d, got %0b %0d",
                                  want.x, want.y, want.odd, want.count,
                                  inside_res, crossings));
      end
    end
  end

  // Watchdog: any accepted operation, result or register write restarts it.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic op, input logic [VIDX_W-1:0] slot,
                          input coord_t x, input coord_t y);
    polygon_op_t item;
    item.opcode = op;
    item.slot   = slot;
    item.x      = x;
    item.y      = y;
    polygon_ops.insert(polygon_ops.size(), item);
    queued_ops++;
    if (op == OP_WRITE) begin
      plan_x[slot]       = x;
      plan_y[slot]       = y;
      plan_written[slot] = 1'b1;
    end
  endtask

  // Directed operations written with plain integer values.
  task automatic queue_fixed(input logic op, input int slot, input int x, input int y);
    queue_op(op, VIDX_W'(slot), coord_t'(x), coord_t'(y));
  endtask

  // Waits until every queued operation went in and every result came out,
  // then lets the block run quiet so a trailing write is surely finished.
  task automatic wait_drained();
    while (accepted_ops != queued_ops || predicted_crossings.size() != 0)
      @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // Writes vertex_count through its channel. Only called while the block is
  // idle, so the shadow copy can change at the handshake edge.
  task automatic program_vertex_count(input logic [CNT_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_count = value;
  endtask

  // Coordinate in one of three styles: full random, a coarse grid that makes
  // shared x values, vertical edges and points on lines common, or extremes.
  function automatic coord_t pick_coord(input int style, input int scale);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'(scale * (int'($urandom_range(16)) - 8));
      default: begin
        case ($urandom_range(6))
          0: return coord_t'(-32768);
          1: return coord_t'(-32767);
          2: return coord_t'(-1);
          3: return coord_t'(0);
          4: return coord_t'(1);
          5: return coord_t'(32766);
          default: return coord_t'(32767);
        endcase
      end
    endcase
  endfunction

  // Query point: often placed on a vertex x, on a vertex, or at the exact
  // midpoint of an edge, so the boundary rules get exercised.
  task automatic queue_query(input int style, input int scale, input int n);
    coord_t qx;
    coord_t qy;
    int     a;
    int     b;
    longint sx;
    longint sy;
    qx = pick_coord(style, scale);
    qy = pick_coord(style, scale);
    if (n > 0) begin
      a = $urandom_range(n - 1);
      b = (a + 1 == n) ? 0 : a + 1;
      case ($urandom_range(4))
        0: qx = plan_x[a];
        1: begin
          qx = plan_x[a];
          qy = plan_y[a];
        end
        2: begin
          sx = longint'(plan_x[a]) + longint'(plan_x[b]);
          sy = longint'(plan_y[a]) + longint'(plan_y[b]);
          if (sx % 2 == 0 && sy % 2 == 0) begin
            qx = coord_t'(sx / 2);
            qy = coord_t'(sy / 2);
          end
        end
        default: ;
      endcase
    end
    queue_op(OP_QUERY, VIDX_W'($urandom), qx, qy);
  endtask

  initial begin
    int   phase;
    int   cnt;
    int   n;
    int   style;
    int   scale;
    int   random_ops;
    int   k;
    logic all_written;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, using the reset vertex count of three.
    // A triangle spanning the whole coordinate range with a horizontal base:
    // points on the base line, at end x values and far corners.
    queue_fixed(OP_WRITE, 0, -32768, -32768);
    queue_fixed(OP_WRITE, 1, 32767, -32768);
    queue_fixed(OP_WRITE, 2, 0, 32767);
    queue_fixed(OP_QUERY, 0, 0, 0);
    queue_fixed(OP_QUERY, 63, -1, -32768);
    queue_fixed(OP_QUERY, 21, 1, 0);
    queue_fixed(OP_QUERY, 42, 32767, 0);
    queue_fixed(OP_QUERY, 0, -32768, 32767);
    queue_fixed(OP_QUERY, 0, 100, -100);
    queue_fixed(OP_QUERY, 0, 0, -32768);
    // A triangle with a vertical edge; one point sits on that edge.
    queue_fixed(OP_WRITE, 0, 5, 5);
    queue_fixed(OP_WRITE, 1, 5, 100);
    queue_fixed(OP_WRITE, 2, 200, 50);
    queue_fixed(OP_QUERY, 0, 50, 50);
    queue_fixed(OP_QUERY, 0, 5, 50);
    queue_fixed(OP_QUERY, 0, 200, 0);
    queue_fixed(OP_QUERY, 0, 6, 5);
    // Full-range diagonal edge: the largest differences and products.
    // The point (0,-1) lies exactly on that diagonal.
    queue_fixed(OP_WRITE, 0, -32768, 32767);
    queue_fixed(OP_WRITE, 1, 32767, -32768);
    queue_fixed(OP_WRITE, 2, 32767, 32767);
    queue_fixed(OP_QUERY, 0, 0, 0);
    queue_fixed(OP_QUERY, 0, 0, -1);
    queue_fixed(OP_QUERY, 0, -32767, 32766);
    queue_fixed(OP_QUERY, 0, 32766, -32767);

    // Random part, in phases. Each phase sets a vertex count while idle, loads
    // a polygon with random content (in order, or just a few of its vertices),
    // then queries it with a sprinkle of stray vertex writes. The first phases
    // walk the corner counts, also counts below three and above the store size.
    phase      = 0;
    random_ops = 0;
    while (random_ops < RANDOM_OPS) begin
      if (phase < $size(corner_counts)) begin
        cnt = corner_counts[phase];
      end else begin
        case ($urandom_range(19))
          0:          cnt = $urandom_range(2);
          1:          cnt = $urandom_range(127, 65);
          2, 3, 4, 5: cnt = $urandom_range(64, 11);
          default:    cnt = $urandom_range(10, 3);
        endcase
      end
      // A long run of phases with the sender never pausing.
      gap_pct = (phase >= 12 && phase < 26) ? 0 : 33;

      wait_drained();
      program_vertex_count(CNT_W'(cnt));
      n = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;

      style = $urandom_range(2);
      case ($urandom_range(4))
        0:       scale = 1;
        1:       scale = 7;
        2:       scale = 100;
        3:       scale = 1000;
        default: scale = 4000;
      endcase

      // Every slot that the queries read must hold a written vertex.
      all_written = 1'b1;
      for (k = 0; k < n; k++)
        if (!plan_written[k]) all_written = 1'b0;
      if (!all_written || $urandom_range(9) < 8) begin
        for (k = 0; k < n; k++)
          queue_op(OP_WRITE, VIDX_W'(k), pick_coord(style, scale), pick_coord(style, scale));
        random_ops += n;
      end else begin
        repeat ($urandom_range(3, 1)) begin
          queue_op(OP_WRITE, VIDX_W'($urandom_range(n - 1)),
                   pick_coord(style, scale), pick_coord(style, scale));
          random_ops++;
        end
      end

      repeat ($urandom_range(10, 3)) begin
        if ($urandom_range(99) < 15) begin
          queue_op(OP_WRITE, VIDX_W'($urandom), pick_coord(style, scale),
                   pick_coord(style, scale));
          random_ops++;
        end
        queue_query(style, scale, n);
        random_ops++;
      end
      phase++;
    end

    wait_drained();
    if (mismatch_count == 0 && predicted_crossings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
